// File: rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RBM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define RBM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/rbm_pkg.sv
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types and constants of the reservoir background model unit.
// ----------------------------------------------------------------------------
package rbm_pkg;

   localparam int PIXELS_DEFAULT = 65536;
   localparam int SLOTS_DEFAULT  = 4;

   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 24;
   localparam int WEIGHT_W   = 9;
   localparam int INDEX_W    = 16;
   localparam int RAND_W     = 16;
   localparam int THR_W      = 9;
   localparam int LIMIT_W    = 8;
   localparam int NUM_W      = 16;
   localparam int LANES      = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 9'd25;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 8'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_LIMIT    = 1'b1;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic [CHAN_W-1:0]  red_in;
      logic [CHAN_W-1:0]  green_in;
      logic [CHAN_W-1:0]  blue_in;
      logic [RAND_W-1:0]  rand_fraction;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] bg_red;
      logic [CHAN_W-1:0] bg_green;
      logic [CHAN_W-1:0] bg_blue;
   } rsp_type;

endpackage

// File: rtl/rbm_mem.sv
// ----------------------------------------------------------------------------
// rbm_mem
// Reservoir storage, one row per pixel, with a weight clearing pass after reset.
// ----------------------------------------------------------------------------
module rbm_mem #(
   parameter int PIXELS = rbm_pkg::PIXELS_DEFAULT,
   parameter int SLOTS  = rbm_pkg::SLOTS_DEFAULT,
   localparam int AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    rd_en,
   input  logic [AW-1:0]                           rd_addr,
   output logic [SLOTS-1:0][rbm_pkg::COLOR_W-1:0]  rd_color,
   output logic [SLOTS-1:0][rbm_pkg::WEIGHT_W-1:0] rd_weight,
   input  logic                                    wr_en,
   input  logic [AW-1:0]                           wr_addr,
   input  logic [SLOTS-1:0][rbm_pkg::COLOR_W-1:0]  wr_color,
   input  logic [SLOTS-1:0][rbm_pkg::WEIGHT_W-1:0] wr_weight,
   output logic                                    busy
);
   import rbm_pkg::*;

   logic [SLOTS-1:0][COLOR_W-1:0]  mem_color  [PIXELS];
   logic [SLOTS-1:0][WEIGHT_W-1:0] mem_weight [PIXELS];

   logic [SLOTS-1:0][COLOR_W-1:0]  rd_color_ff;
   logic [SLOTS-1:0][WEIGHT_W-1:0] rd_weight_ff;
   logic [AW-1:0]                  clr_addr_ff;
   logic                           busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(PIXELS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem_weight[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem_weight[wr_addr] <= wr_weight;
      end
      if (wr_en && !busy_ff) begin
         mem_color[wr_addr] <= wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_color_ff  <= mem_color[rd_addr];
         rd_weight_ff <= mem_weight[rd_addr];
      end
   end

   assign rd_color  = rd_color_ff;
   assign rd_weight = rd_weight_ff;
   assign busy      = busy_ff;

endmodule

// File: rtl/rbm_div.sv
// ----------------------------------------------------------------------------
// rbm_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module rbm_div (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [rbm_pkg::LANES-1:0][rbm_pkg::NUM_W-1:0]  num,
   input  logic [rbm_pkg::WEIGHT_W-1:0]                   den,
   output logic                                           done,
   output logic [rbm_pkg::LANES-1:0][rbm_pkg::CHAN_W-1:0] quo
);
   import rbm_pkg::*;

   localparam int CW = $clog2(NUM_W);

   logic                                busy_ff;
   logic                                done_ff;
   logic [CW-1:0]                       cnt_ff;
   logic [WEIGHT_W-1:0]                 den_ff;
   logic [LANES-1:0][WEIGHT_W-1:0]      rem_ff;
   logic [LANES-1:0][NUM_W-1:0]         quo_ff;
   logic [LANES-1:0][WEIGHT_W-1:0]      rem_in;
   logic [LANES-1:0][NUM_W-1:0]         quo_in;

   always_comb begin
      logic [WEIGHT_W:0] t;
      logic              ge;
      for (int k = 0; k < LANES; k++) begin
         t         = {rem_ff[k], quo_ff[k][NUM_W-1]};
         ge        = (t >= {1'b0, den_ff});
         rem_in[k] = ge ? WEIGHT_W'(t - {1'b0, den_ff}) : t[WEIGHT_W-1:0];
         quo_in[k] = {quo_ff[k][NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= num;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         quo[k] = quo_ff[k][CHAN_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

// File: rtl/reservoir_background_model_unit.sv
// ----------------------------------------------------------------------------
// reservoir_background_model_unit
// Per-pixel weighted reservoir background estimator.
//
// req_* carries one pixel (position, colour, random fraction); rsp_* returns
// the background colour for it, one transaction out for each one in.
// csr_* writes the match threshold (index 0) and the weight limit (index 1).
// One pixel is in flight at a time. An accepted pixel passes through S_MOD
// and S_REM, reducing its position modulo PIXELS, then S_RD reading its
// reservoir row, S_EVAL evaluating, S_MUL multiplying, S_DIV in the divider
// when it joins a reservoir, and S_WB writing back; the next pixel is
// accepted only once the unit is back in S_IDLE after its write-back.
// The row read/modify/write in the single reservoir memory is why no new
// pixel is taken before the last one is written back.
// After reset the weights are cleared one row per cycle, with req_ready low
// meanwhile. The result sits in an output register; when the receiver
// stalls it holds, and the next pixel may already be accepted and worked on
// until its own write-back waits for that register to drain.
// ----------------------------------------------------------------------------
module reservoir_background_model_unit #(
   parameter int PIXELS = rbm_pkg::PIXELS_DEFAULT,
   parameter int SLOTS  = rbm_pkg::SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rbm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rbm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [rbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rbm_pkg::CSR_DATA_W-1:0]     csr_data
);
   import rbm_pkg::*;

   localparam int AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TOT_W = $clog2(SLOTS * 255 + 1);
   localparam int RP_W  = RAND_W + TOT_W;
   localparam int DIV_L = (PIXELS > 1) ? $clog2(PIXELS) : 0;
   localparam int DIV_S = INDEX_W + DIV_L;
   localparam bit PIX_WIDE = (PIXELS > (1 << INDEX_W));
   localparam longint RECIP_L = PIX_WIDE ? 0 :
      ((longint'(1) << DIV_S) + longint'(PIXELS) - 1) / longint'(PIXELS);
   localparam logic [INDEX_W:0] RECIP = (INDEX_W + 1)'(RECIP_L);
   localparam logic [INDEX_W:0] PIX_M = PIX_WIDE ? '0 : (INDEX_W + 1)'(PIXELS);

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_REM, S_RD, S_EVAL, S_MUL, S_DIV, S_WB
   } state_type;

   typedef enum logic [1:0] {UPD_MATCH, UPD_EMPTY, UPD_REPLACE} upd_type;

   state_type                      state_ff;
   logic                           rsp_valid_ff;
   rsp_type                        rsp_ff;
   logic [THR_W-1:0]               thr_ff;
   logic [LIMIT_W-1:0]             limit_ff;
   req_type                        req_ff;
   logic [INDEX_W-1:0]             q_ff;
   logic [AW-1:0]                  rem_ff;
   upd_type                        upd_ff;
   logic [SW-1:0]                  slot_ff;
   logic [WEIGHT_W-1:0]            wnew_ff;
   logic [WEIGHT_W-1:0]            least_ff;
   logic [TOT_W-1:0]               total_ff;
   logic [RP_W-1:0]                rp_ff;
   logic [SLOTS-1:0][COLOR_W-1:0]  color_ff;
   logic [SLOTS-1:0][WEIGHT_W-1:0] weight_ff;

   logic [SLOTS-1:0][COLOR_W-1:0]  rd_color;
   logic [SLOTS-1:0][WEIGHT_W-1:0] rd_weight;
   logic                           mem_busy;
   logic                           wb_go;
   logic                           div_done;
   logic [LANES-1:0][NUM_W-1:0]    div_num;
   logic [LANES-1:0][CHAN_W-1:0]   div_quo;
   logic [SLOTS-1:0][COLOR_W-1:0]  wb_color;
   logic [SLOTS-1:0][WEIGHT_W-1:0] wb_weight;
   rsp_type                        rsp_in;
   logic [INDEX_W-1:0]             q_in;
   logic [AW-1:0]                  rem_in;
   upd_type                        upd_in;
   logic [SW-1:0]                  slot_in;
   logic [WEIGHT_W-1:0]            least_in;
   logic [TOT_W-1:0]               total_in;

   function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THRESHOLD_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COLOR_THRESHOLD: thr_ff <= csr_data[THR_W-1:0];
            CSR_WEIGHT_LIMIT:    limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // position modulo frame size by reciprocal multiplication
   always_comb begin
      logic [2*INDEX_W:0] prod;
      prod = {{INDEX_W{1'b0}}, RECIP} * {{(INDEX_W + 1){1'b0}}, req_ff.pixel_index};
      q_in = INDEX_W'(prod >> DIV_S);
   end

   always_comb begin
      logic [2*INDEX_W:0] qp;
      logic [INDEX_W-1:0] diff;
      qp     = {{(INDEX_W + 1){1'b0}}, q_ff} * {{INDEX_W{1'b0}}, PIX_M};
      diff   = req_ff.pixel_index - qp[INDEX_W-1:0];
      rem_in = AW'(diff);
   end

   // match, last empty, lightest and total over the row
   always_comb begin
      logic              found;
      logic              empty_found;
      logic [SW-1:0]     match_idx;
      logic [SW-1:0]     empty_idx;
      logic [SW-1:0]     lo;
      logic [CHAN_W-1:0] cr, cg, cb;
      found       = 1'b0;
      empty_found = 1'b0;
      match_idx   = '0;
      empty_idx   = '0;
      lo          = '0;
      least_in    = rd_weight[0];
      total_in    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         cr = rd_color[i][23:16];
         cg = rd_color[i][15:8];
         cb = rd_color[i][7:0];
         if (!found) begin
            if (rd_weight[i] != '0) begin
               if ({1'b0, absdiff(cr, req_ff.red_in)} < thr_ff &&
                   {1'b0, absdiff(cg, req_ff.green_in)} < thr_ff &&
                   {1'b0, absdiff(cb, req_ff.blue_in)} < thr_ff) begin
                  found     = 1'b1;
                  match_idx = SW'(i);
               end
            end else begin
               empty_found = 1'b1;
               empty_idx   = SW'(i);
            end
         end
         if (rd_weight[i] < least_in) begin
            least_in = rd_weight[i];
            lo       = SW'(i);
         end
         total_in = total_in + TOT_W'(rd_weight[i]);
      end
      if (found) begin
         upd_in  = UPD_MATCH;
         slot_in = match_idx;
      end else if (empty_found) begin
         upd_in  = UPD_EMPTY;
         slot_in = empty_idx;
      end else begin
         upd_in  = UPD_REPLACE;
         slot_in = lo;
      end
   end

   // running mean numerators
   always_comb begin
      logic [COLOR_W-1:0]  c;
      logic [COLOR_W-1:0]  n;
      logic [WEIGHT_W-1:0] wm1;
      logic [16:0]         p;
      c   = color_ff[slot_ff];
      n   = {req_ff.red_in, req_ff.green_in, req_ff.blue_in};
      wm1 = wnew_ff - 1'b1;
      for (int k = 0; k < LANES; k++) begin
         p          = wm1 * c[(LANES-1-k)*CHAN_W +: CHAN_W];
         div_num[k] = p[NUM_W-1:0] + NUM_W'(n[(LANES-1-k)*CHAN_W +: CHAN_W]);
      end
   end

   // row update, clamp and heaviest pick
   always_comb begin
      logic [WEIGHT_W-1:0] best;
      logic [SW-1:0]       bi;
      logic [WEIGHT_W-1:0] lim;
      wb_color  = color_ff;
      wb_weight = weight_ff;
      lim       = {1'b0, limit_ff};
      case (upd_ff)
         UPD_MATCH: begin
            wb_weight[slot_ff] = wnew_ff;
            wb_color[slot_ff]  = {div_quo[0], div_quo[1], div_quo[2]};
         end
         UPD_EMPTY: begin
            wb_weight[slot_ff] = WEIGHT_W'(1);
            wb_color[slot_ff]  = {req_ff.red_in, req_ff.green_in, req_ff.blue_in};
         end
         UPD_REPLACE: begin
            if (32'(rp_ff) >= 32'({least_ff, 16'h0000})) begin
               wb_weight[slot_ff] = WEIGHT_W'(1);
               wb_color[slot_ff]  = {req_ff.red_in, req_ff.green_in, req_ff.blue_in};
            end
         end
         default: ;
      endcase
      best = '0;
      bi   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (wb_weight[i] > lim) begin
            wb_weight[i] = lim;
         end
         if (wb_weight[i] > best) begin
            best = wb_weight[i];
            bi   = SW'(i);
         end
      end
      rsp_in.bg_red   = wb_color[bi][23:16];
      rsp_in.bg_green = wb_color[bi][15:8];
      rsp_in.bg_blue  = wb_color[bi][7:0];
   end

   assign wb_go = (state_ff == S_WB) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wb_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  state_ff <= S_MOD;
               end
            end
            S_MOD:  state_ff <= S_REM;
            S_REM:  state_ff <= S_RD;
            S_RD:   state_ff <= S_EVAL;
            S_EVAL: state_ff <= S_MUL;
            S_MUL:  state_ff <= (upd_ff == UPD_MATCH) ? S_DIV : S_WB;
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_WB;
               end
            end
            S_WB: begin
               if (wb_go) begin
                  rsp_ff   <= rsp_in;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (state_ff == S_MOD) begin
         q_ff <= q_in;
      end
      if (state_ff == S_REM) begin
         rem_ff <= rem_in;
      end
      if (state_ff == S_EVAL) begin
         upd_ff    <= upd_in;
         slot_ff   <= slot_in;
         least_ff  <= least_in;
         total_ff  <= total_in;
         wnew_ff   <= rd_weight[slot_in] + 1'b1;
         color_ff  <= rd_color;
         weight_ff <= rd_weight;
      end
      if (state_ff == S_MUL) begin
         rp_ff <= RP_W'(req_ff.rand_fraction) * RP_W'(total_ff);
      end
   end

   rbm_mem #(
      .PIXELS (PIXELS),
      .SLOTS  (SLOTS)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (state_ff == S_RD),
      .rd_addr   (rem_ff),
      .rd_color  (rd_color),
      .rd_weight (rd_weight),
      .wr_en     (wb_go),
      .wr_addr   (rem_ff),
      .wr_color  (wb_color),
      .wr_weight (wb_weight),
      .busy      (mem_busy)
   );

   rbm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_MUL && upd_ff == UPD_MATCH),
      .num   (div_num),
      .den   (wnew_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign req_ready = (state_ff == S_IDLE) && !mem_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/rbm_checker.sv
// ----------------------------------------------------------------------------
// rbm_checker
// Port-level checks of the reservoir background model unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rbm_pkg::rsp_type rsp_data
);
   import rbm_pkg::*;

   `RBM_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready)
   `RBM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `RBM_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready && !rsp_valid, !rsp_valid)
   `RBM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind reservoir_background_model_unit rbm_checker u_rbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reservoir background model unit. Pixels are
// sent over the request channel and run through a local model of the per-pixel
// reservoirs. Each returned background colour is compared with the oldest
// predicted one. Match threshold and weight limit are swept across their
// extremes between phases, and both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
   import rbm_pkg::*;

   localparam int NPIX      = PIXELS_DEFAULT;
   localparam int NSLOT     = SLOTS_DEFAULT;
   localparam int LIMIT     = 1000000;
   localparam int POOL      = 16;
   localparam int PHASE_LEN = 125;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   logic [COLOR_W-1:0]  bank_color [NPIX*NSLOT];
   logic [WEIGHT_W-1:0] bank_weight [NPIX*NSLOT];
   logic [THR_W-1:0]    cur_threshold;
   logic [LIMIT_W-1:0]  cur_limit;

   rsp_type         bg_expect_q [$];
   int              fail_count;
   int              cycle_count;
   bit              calm;
   logic [15:0]     pool_pix [POOL];
   logic [23:0]     pool_base [POOL];

   reservoir_background_model_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] chan_diff(logic [7:0] a, logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [7:0] chan_mean(logic [7:0] old_v, logic [7:0] new_v, int w);
      int s;
      s = ((w - 1) * old_v + new_v) / w;
      return s[7:0];
   endfunction

   function automatic rsp_type bg_predict(req_type t);
      int base, match_i, empty_i, lo, bi, w;
      longint least, total, best;
      logic [23:0] c;
      rsp_type r;
      base = int'(t.pixel_index) * NSLOT;
      match_i = -1;
      empty_i = -1;
      for (int i = 0; i < NSLOT; i++) begin
         c = bank_color[base+i];
         if (bank_weight[base+i] > 0) begin
            if (chan_diff(c[23:16], t.red_in) < cur_threshold &&
                chan_diff(c[15:8], t.green_in) < cur_threshold &&
                chan_diff(c[7:0], t.blue_in) < cur_threshold) begin
               match_i = i;
               break;
            end
         end else begin
            empty_i = i;
         end
      end
      if (match_i >= 0) begin
         w = bank_weight[base+match_i] + 1;
         c = bank_color[base+match_i];
         bank_weight[base+match_i] = w[8:0];
         bank_color[base+match_i] = {chan_mean(c[23:16], t.red_in, w),
                                     chan_mean(c[15:8], t.green_in, w),
                                     chan_mean(c[7:0], t.blue_in, w)};
      end else if (empty_i >= 0) begin
         bank_color[base+empty_i] = {t.red_in, t.green_in, t.blue_in};
         bank_weight[base+empty_i] = 9'd1;
      end else begin
         lo = 0;
         least = longint'(bank_weight[base]);
         total = longint'(bank_weight[base]);
         for (int i = 1; i < NSLOT; i++) begin
            if (bank_weight[base+i] < least) begin
               least = longint'(bank_weight[base+i]);
               lo = i;
            end
            total += longint'(bank_weight[base+i]);
         end
         if (longint'(t.rand_fraction) * total >= least * 65536) begin
            bank_color[base+lo] = {t.red_in, t.green_in, t.blue_in};
            bank_weight[base+lo] = 9'd1;
         end
      end
      best = 0;
      bi = 0;
      for (int i = 0; i < NSLOT; i++) begin
         if (bank_weight[base+i] > cur_limit)
            bank_weight[base+i] = {1'b0, cur_limit};
         if (bank_weight[base+i] > best) begin
            best = longint'(bank_weight[base+i]);
            bi = i;
         end
      end
      c = bank_color[base+bi];
      r.bg_red = c[23:16];
      r.bg_green = c[15:8];
      r.bg_blue = c[7:0];
      return r;
   endfunction

   task automatic send_pixel(logic [15:0] pix, logic [23:0] color, logic [15:0] frac);
      req_type t;
      t.pixel_index = pix;
      t.red_in = color[23:16];
      t.green_in = color[15:8];
      t.blue_in = color[7:0];
      t.rand_fraction = frac;
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      bg_expect_q.push_back(bg_predict(t));
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (bg_expect_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_COLOR_THRESHOLD)
         cur_threshold = value;
      else
         cur_limit = value[LIMIT_W-1:0];
   endtask

   function automatic logic [7:0] jitter(logic [7:0] v, int span);
      int x;
      x = int'(v) + $urandom_range(0, 2 * span) - span;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      return x[7:0];
   endfunction

   task automatic test_directed();
      send_pixel(16'h0000, 24'h000000, 16'h0000);
      send_pixel(16'hFFFF, 24'hFFFFFF, 16'hFFFF);
      send_pixel(16'h0000, 24'h000000, 16'hFFFF);
      send_pixel(16'h0000, 24'h0A0B0C, 16'h0000);
      send_pixel(16'h0000, 24'h808080, 16'h1234);
      send_pixel(16'h0000, 24'hFF0000, 16'h0000);
      send_pixel(16'h0000, 24'h00FF00, 16'h0000);
      // row full, no replace with zero fraction
      send_pixel(16'h0000, 24'h0000FF, 16'h0000);
      send_pixel(16'h0000, 24'h0000FF, 16'hFFFF);
      send_pixel(16'h0000, 24'h0000FF, 16'h8000);
      send_pixel(16'h0000, 24'h818181, 16'h0000);
      send_pixel(16'h0000, 24'h989898, 16'h0000);
      send_pixel(16'h0000, 24'h999999, 16'h0000);
      send_pixel(16'hFFFF, 24'hF0F0F0, 16'h0000);
      send_pixel(16'hFFFF, 24'hE7FFFF, 16'h0000);
      send_pixel(16'hAAAA, 24'hAA55AA, 16'hAAAA);
      send_pixel(16'h5555, 24'h55AA55, 16'h5555);
   endtask

   task automatic run_random(int count);
      int k, span;
      logic [15:0] pix;
      logic [23:0] col;
      for (int n = 0; n < count; n++) begin
         span = $urandom_range(0, 3) == 0 ? 60 : 12;
         if ($urandom_range(0, 9) == 0) begin
            pix = 16'($urandom);
            col = 24'($urandom);
         end else begin
            k = $urandom_range(0, POOL - 1);
            pix = pool_pix[k];
            if ($urandom_range(0, 4) == 0)
               pool_base[k] = 24'($urandom);
            col = {jitter(pool_base[k][23:16], span), jitter(pool_base[k][15:8], span),
                   jitter(pool_base[k][7:0], span)};
         end
         send_pixel(pix, col, 16'($urandom));
      end
   endtask

   task automatic test_reset_settings();
      run_random(PHASE_LEN);
   endtask

   task automatic test_wide_settings();
      write_csr(CSR_COLOR_THRESHOLD, 9'd256);
      write_csr(CSR_WEIGHT_LIMIT, 9'd255);
      run_random(PHASE_LEN);
   endtask

   task automatic test_narrow_settings();
      write_csr(CSR_COLOR_THRESHOLD, 9'd1);
      write_csr(CSR_WEIGHT_LIMIT, 9'd1);
      run_random(PHASE_LEN);
   endtask

   task automatic test_threshold_edges();
      write_csr(CSR_COLOR_THRESHOLD, 9'd0);
      write_csr(CSR_WEIGHT_LIMIT, 9'd3);
      run_random(60);
      write_csr(CSR_COLOR_THRESHOLD, 9'h1FF);
      write_csr(CSR_WEIGHT_LIMIT, 9'hFF);
      run_random(60);
   endtask

   task automatic test_mixed_settings();
      write_csr(CSR_COLOR_THRESHOLD, 9'($urandom_range(5, 60)));
      write_csr(CSR_WEIGHT_LIMIT, 9'($urandom_range(2, 40)));
      run_random(PHASE_LEN);
      calm = 1'b1;
      write_csr(CSR_COLOR_THRESHOLD, 9'd30);
      write_csr(CSR_WEIGHT_LIMIT, 9'd200);
      run_random(PHASE_LEN);
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      fail_count = 0;
      calm = 1'b0;
      cur_threshold = THRESHOLD_RESET;
      cur_limit = LIMIT_RESET;
      for (int i = 0; i < NPIX * NSLOT; i++) begin
         bank_weight[i] = '0;
         bank_color[i] = '0;
      end
      for (int i = 0; i < POOL; i++) begin
         pool_pix[i] = 16'($urandom);
         pool_base[i] = 24'($urandom);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_reset_settings();
      test_wide_settings();
      test_narrow_settings();
      test_threshold_edges();
      test_mixed_settings();
      wait_drained();
      if (fail_count == 0)
         $display("PASS reservoir_background_model_unit");
      else
         $display("FAIL reservoir_background_model_unit");
      $finish;
   end

   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (bg_expect_q.size() == 0) begin
            $display("%0t unexpected transaction: actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            if (rsp_data.bg_red !== bg_expect_q[0].bg_red) begin
               $display("%0t bg_red mismatch: expected %h actual %h", $time,
                        bg_expect_q[0].bg_red, rsp_data.bg_red);
               fail_count++;
            end
            if (rsp_data.bg_green !== bg_expect_q[0].bg_green) begin
               $display("%0t bg_green mismatch: expected %h actual %h", $time,
                        bg_expect_q[0].bg_green, rsp_data.bg_green);
               fail_count++;
            end
            if (rsp_data.bg_blue !== bg_expect_q[0].bg_blue) begin
               $display("%0t bg_blue mismatch: expected %h actual %h", $time,
                        bg_expect_q[0].bg_blue, rsp_data.bg_blue);
               fail_count++;
            end
            void'(bg_expect_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("FAIL reservoir_background_model_unit");
         $finish;
      end
   end

   initial cycle_count = 0;

endmodule
